// ----- rtl/gbsp_pkg.sv -----
// ----------------------------------------------------------------------------
// gbsp_pkg
// Types and constants for the GIF block structure parser.
// ----------------------------------------------------------------------------
package gbsp_pkg;

  // parser phase, one-hot
  typedef enum logic [14:0] {
    PH_SIG     = 15'h0001,
    PH_LSD     = 15'h0002,
    PH_GCT     = 15'h0004,
    PH_BLOCK   = 15'h0008,
    PH_IMG     = 15'h0010,
    PH_LCT     = 15'h0020,
    PH_LZW     = 15'h0040,
    PH_SUBSZ   = 15'h0080,
    PH_SUBDATA = 15'h0100,
    PH_LABEL   = 15'h0200,
    PH_GCE     = 15'h0400,
    PH_APPSZ   = 15'h0800,
    PH_APP     = 15'h1000,
    PH_PTSKIP  = 15'h2000,
    PH_DONE    = 15'h4000
  } phase_t;

  // record kinds
  localparam logic [3:0] REC_HEADER    = 4'd0;
  localparam logic [3:0] REC_SCREEN    = 4'd1;
  localparam logic [3:0] REC_IMAGE     = 4'd2;
  localparam logic [3:0] REC_LZW       = 4'd3;
  localparam logic [3:0] REC_GCE       = 4'd4;
  localparam logic [3:0] REC_APP       = 4'd5;
  localparam logic [3:0] REC_COMMENT   = 4'd6;
  localparam logic [3:0] REC_PTEXT     = 4'd7;
  localparam logic [3:0] REC_PAYLOAD   = 4'd8;
  localparam logic [3:0] REC_TRAILER   = 4'd9;
  localparam logic [3:0] REC_ERR_END   = 4'd10;
  localparam logic [3:0] REC_ERR_TYPE  = 4'd11;
  localparam logic [3:0] REC_ERR_AFTER = 4'd12;
  localparam logic [3:0] REC_ERR_APPSZ = 4'd13;

  // sub-block owner
  localparam logic [1:0] EXT_IMAGE   = 2'd0;
  localparam logic [1:0] EXT_COMMENT = 2'd1;
  localparam logic [1:0] EXT_APP     = 2'd2;
  localparam logic [1:0] EXT_PTEXT   = 2'd3;

  // block introducers and labels
  localparam logic [7:0] BT_IMAGE    = 8'h2C;
  localparam logic [7:0] BT_EXT      = 8'h21;
  localparam logic [7:0] BT_TRAILER  = 8'h3B;
  localparam logic [7:0] LBL_GCE     = 8'hF9;
  localparam logic [7:0] LBL_COMMENT = 8'hFE;
  localparam logic [7:0] LBL_APP     = 8'hFF;
  localparam logic [7:0] LBL_PTEXT   = 8'h01;
  localparam logic [7:0] APP_BLK_SZ  = 8'd11;
  localparam logic [9:0] PTEXT_SKIP  = 10'd13;

  typedef struct packed {
    logic [3:0]  kind;
    logic [63:0] text_word;
    logic [23:0] auth_code;
    logic [15:0] left;
    logic [15:0] top;
    logic [15:0] width;
    logic [15:0] height;
    logic [2:0]  flag_bits;
    logic [8:0]  table_entries;
    logic [7:0]  small_value;
    logic [7:0]  index_value;
    logic [15:0] delay_ticks;
  } rec_t;

  // color table entries from the packed size field
  function automatic logic [8:0] table_size(input logic [2:0] sz);
    return 9'd2 << sz;
  endfunction

  // color table length in bytes
  function automatic logic [9:0] table_bytes(input logic [2:0] sz);
    logic [9:0] n;
    n = {1'b0, table_size(sz)};
    return (n << 1) + n;
  endfunction

endpackage

// ----- rtl/gif_block_structure_parser.sv -----
// ----------------------------------------------------------------------------
// gif_block_structure_parser
// Walks a GIF89a byte stream and emits one decoded record per structure.
// ----------------------------------------------------------------------------
//  channel | signals                                   | dir
//  --------+-------------------------------------------+-----
//  in      | in_valid, in_ready, data_byte, end_of_stream | in
//  out     | out_valid, out_ready, record fields        | out
//  cfg     | cfg_we, cfg_wdata (emit_payload)          | in
//
//  One word per cycle: each byte is decoded in the cycle it is accepted and
//  its record, if any, lands in the output register at that edge.
//  in_ready drops only while the output register holds a record not taken.
//  Reset clears phase, counters, halt flag and output valid; no clearing pass.
//  Errors halt the parser until reset; halted words are consumed silently.
// ----------------------------------------------------------------------------
module gif_block_structure_parser
  import gbsp_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  data_byte,
  input  logic        end_of_stream,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [3:0]  record_kind,
  output logic [63:0] text_word,
  output logic [23:0] auth_code,
  output logic [15:0] left,
  output logic [15:0] top,
  output logic [15:0] width,
  output logic [15:0] height,
  output logic [2:0]  flag_bits,
  output logic [8:0]  table_entries,
  output logic [7:0]  small_value,
  output logic [7:0]  index_value,
  output logic [15:0] delay_ticks,
  input  logic        cfg_we,
  input  logic        cfg_wdata
);

  phase_t      phase, phase_next;
  logic [3:0]  byte_index, byte_index_next;
  logic [9:0]  skip_remaining, skip_remaining_next;
  logic [7:0]  sub_block_remaining, sub_block_remaining_next;
  logic [1:0]  extension_type, extension_type_next;
  logic        halted, halted_next;
  logic        emit_payload;
  logic [7:0]  field_store [11];
  logic        fs_we;

  rec_t        res;
  logic        res_valid;
  rec_t        out_rec;
  logic        acc;

  assign in_ready = !out_valid || out_ready;
  assign acc      = in_valid && in_ready;

  always_comb begin
    phase_next               = phase;
    byte_index_next          = byte_index;
    skip_remaining_next      = skip_remaining;
    sub_block_remaining_next = sub_block_remaining;
    extension_type_next      = extension_type;
    halted_next              = halted;
    fs_we                    = 1'b0;
    res                      = '0;
    res_valid                = 1'b0;
    if (!halted) begin
      if (phase == PH_DONE) begin
        if (!end_of_stream) begin
          res.kind    = REC_ERR_AFTER;
          res_valid   = 1'b1;
          halted_next = 1'b1;
        end
      end else if (end_of_stream) begin
        res.kind    = REC_ERR_END;
        res_valid   = 1'b1;
        halted_next = 1'b1;
      end else begin
        case (phase)
          PH_SIG: begin
            fs_we = 1'b1;
            if (byte_index == 4'd5) begin
              byte_index_next = '0;
              phase_next      = PH_LSD;
              res.kind        = REC_HEADER;
              res.text_word   = {16'd0, field_store[0], field_store[1], field_store[2],
                                 field_store[3], field_store[4], data_byte};
              res_valid       = 1'b1;
            end else begin
              byte_index_next = byte_index + 4'd1;
            end
          end
          PH_LSD: begin
            fs_we = 1'b1;
            if (byte_index == 4'd6) begin
              byte_index_next   = '0;
              res.kind          = REC_SCREEN;
              res.width         = {field_store[1], field_store[0]};
              res.height        = {field_store[3], field_store[2]};
              res.flag_bits     = {1'b0, field_store[4][3], field_store[4][7]};
              res.table_entries = field_store[4][7] ? table_size(field_store[4][2:0]) : 9'd0;
              res.small_value   = {5'd0, field_store[4][6:4]} + 8'd1;
              res.index_value   = field_store[5];
              res_valid         = 1'b1;
              if (field_store[4][7]) begin
                skip_remaining_next = table_bytes(field_store[4][2:0]);
                phase_next          = PH_GCT;
              end else begin
                phase_next = PH_BLOCK;
              end
            end else begin
              byte_index_next = byte_index + 4'd1;
            end
          end
          PH_GCT, PH_LCT, PH_PTSKIP: begin
            if (skip_remaining != '0) begin
              skip_remaining_next = skip_remaining - 10'd1;
            end
            if (skip_remaining <= 10'd1) begin
              phase_next = (phase == PH_GCT) ? PH_BLOCK :
                           (phase == PH_LCT) ? PH_LZW : PH_SUBSZ;
            end
          end
          PH_BLOCK: begin
            if (data_byte == BT_IMAGE) begin
              byte_index_next = '0;
              phase_next      = PH_IMG;
            end else if (data_byte == BT_EXT) begin
              phase_next = PH_LABEL;
            end else if (data_byte == BT_TRAILER) begin
              phase_next = PH_DONE;
              res.kind   = REC_TRAILER;
              res_valid  = 1'b1;
            end else begin
              res.kind        = REC_ERR_TYPE;
              res.small_value = data_byte;
              res_valid       = 1'b1;
              halted_next     = 1'b1;
            end
          end
          PH_IMG: begin
            fs_we = 1'b1;
            if (byte_index == 4'd8) begin
              // packed byte is the word on the wire right now
              byte_index_next   = '0;
              res.kind          = REC_IMAGE;
              res.left          = {field_store[1], field_store[0]};
              res.top           = {field_store[3], field_store[2]};
              res.width         = {field_store[5], field_store[4]};
              res.height        = {field_store[7], field_store[6]};
              res.flag_bits     = {data_byte[6], data_byte[5], data_byte[7]};
              res.table_entries = data_byte[7] ? table_size(data_byte[2:0]) : 9'd0;
              res_valid         = 1'b1;
              if (data_byte[7]) begin
                skip_remaining_next = table_bytes(data_byte[2:0]);
                phase_next          = PH_LCT;
              end else begin
                phase_next = PH_LZW;
              end
            end else begin
              byte_index_next = byte_index + 4'd1;
            end
          end
          PH_LZW: begin
            extension_type_next = EXT_IMAGE;
            phase_next          = PH_SUBSZ;
            res.kind            = REC_LZW;
            res.small_value     = data_byte;
            res_valid           = 1'b1;
          end
          PH_SUBSZ: begin
            if (data_byte == 8'd0) begin
              phase_next = PH_BLOCK;
            end else begin
              sub_block_remaining_next = data_byte;
              phase_next               = PH_SUBDATA;
            end
          end
          PH_SUBDATA: begin
            sub_block_remaining_next = sub_block_remaining - 8'd1;
            if (sub_block_remaining == 8'd1) begin
              phase_next = PH_SUBSZ;
            end
            if (extension_type != EXT_IMAGE && emit_payload) begin
              res.kind        = REC_PAYLOAD;
              res.small_value = data_byte;
              res_valid       = 1'b1;
            end
          end
          PH_LABEL: begin
            byte_index_next = '0;
            if (data_byte == LBL_GCE) begin
              phase_next = PH_GCE;
            end else if (data_byte == LBL_APP) begin
              phase_next = PH_APPSZ;
            end else if (data_byte == LBL_COMMENT) begin
              extension_type_next = EXT_COMMENT;
              phase_next          = PH_SUBSZ;
              res.kind            = REC_COMMENT;
              res_valid           = 1'b1;
            end else if (data_byte == LBL_PTEXT) begin
              extension_type_next = EXT_PTEXT;
              skip_remaining_next = PTEXT_SKIP;
              phase_next          = PH_PTSKIP;
              res.kind            = REC_PTEXT;
              res_valid           = 1'b1;
            end else begin
              // unknown label: drop it, next word is a block type
              phase_next = PH_BLOCK;
            end
          end
          PH_GCE: begin
            fs_we = 1'b1;
            if (byte_index == 4'd5) begin
              byte_index_next = '0;
              phase_next      = PH_BLOCK;
              res.kind        = REC_GCE;
              res.flag_bits   = {1'b0, field_store[1][1], field_store[1][0]};
              res.small_value = {5'd0, field_store[1][4:2]};
              res.index_value = field_store[4];
              res.delay_ticks = {field_store[3], field_store[2]};
              res_valid       = 1'b1;
            end else begin
              byte_index_next = byte_index + 4'd1;
            end
          end
          PH_APPSZ: begin
            if (data_byte != APP_BLK_SZ) begin
              res.kind        = REC_ERR_APPSZ;
              res.small_value = data_byte;
              res_valid       = 1'b1;
              halted_next     = 1'b1;
            end else begin
              byte_index_next = '0;
              phase_next      = PH_APP;
            end
          end
          PH_APP: begin
            fs_we = 1'b1;
            if (byte_index == 4'd10) begin
              byte_index_next     = '0;
              extension_type_next = EXT_APP;
              phase_next          = PH_SUBSZ;
              res.kind            = REC_APP;
              res.text_word       = {field_store[0], field_store[1], field_store[2],
                                     field_store[3], field_store[4], field_store[5],
                                     field_store[6], field_store[7]};
              res.auth_code       = {field_store[8], field_store[9], data_byte};
              res_valid           = 1'b1;
            end else begin
              byte_index_next = byte_index + 4'd1;
            end
          end
          default: begin
            phase_next = PH_BLOCK;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase               <= PH_SIG;
      byte_index          <= '0;
      skip_remaining      <= '0;
      sub_block_remaining <= '0;
      extension_type      <= EXT_IMAGE;
      halted              <= 1'b0;
    end else if (acc) begin
      phase               <= phase_next;
      byte_index          <= byte_index_next;
      skip_remaining      <= skip_remaining_next;
      sub_block_remaining <= sub_block_remaining_next;
      extension_type      <= extension_type_next;
      halted              <= halted_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      emit_payload <= 1'b0;
    end else if (cfg_we) begin
      emit_payload <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (acc && fs_we) begin
      field_store[byte_index] <= data_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (acc && res_valid) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (acc && res_valid) begin
      out_rec <= res;
    end
  end

  assign record_kind   = out_rec.kind;
  assign text_word     = out_rec.text_word;
  assign auth_code     = out_rec.auth_code;
  assign left          = out_rec.left;
  assign top           = out_rec.top;
  assign width         = out_rec.width;
  assign height        = out_rec.height;
  assign flag_bits     = out_rec.flag_bits;
  assign table_entries = out_rec.table_entries;
  assign small_value   = out_rec.small_value;
  assign index_value   = out_rec.index_value;
  assign delay_ticks   = out_rec.delay_ticks;

  // a halted parser swallows words without producing records
  a_halt_silent: assert property (@(posedge clk) disable iff (rst)
    (halted && acc) |=> !out_valid)
    else $error("record produced while halted");

  // an error record in the output register means the parser is halted
  a_err_halts: assert property (@(posedge clk) disable iff (rst)
    (out_valid && record_kind >= REC_ERR_END) |-> halted)
    else $error("error record without halt");

  // skip phases always have bytes left to drop
  a_skip_nonzero: assert property (@(posedge clk) disable iff (rst)
    (phase == PH_GCT || phase == PH_LCT || phase == PH_PTSKIP) |-> skip_remaining != '0)
    else $error("skip phase with empty count");

  // sub-block data phase always has bytes left
  a_sub_nonzero: assert property (@(posedge clk) disable iff (rst)
    (phase == PH_SUBDATA) |-> sub_block_remaining != '0)
    else $error("sub-block data phase with empty count");

  a_phase_onehot: assert property (@(posedge clk) disable iff (rst)
    $onehot(phase))
    else $error("phase not one-hot");

endmodule
